// ===== sv/rsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar sweep controller package
// Shared widths, command codes, sweep direction type, segment encoding and
// constant divide-by-ten helper.
// ----------------------------------------------------------------------------
package rsc_pkg;

  localparam int CMD_W   = 8;
  localparam int DIST_W  = 12;
  localparam int STEP_W  = 5;
  localparam int ANGLE_W = 8;
  localparam int SPEED_W = 4;
  localparam int SERVO_W = 12;
  localparam int DELAY_W = 17;

  localparam logic [CMD_W-1:0] CHAR_0  = 8'h30;
  localparam logic [CMD_W-1:0] CHAR_9  = 8'h39;
  localparam logic [CMD_W-1:0] CHAR_LA = 8'h61;
  localparam logic [CMD_W-1:0] CHAR_LZ = 8'h7A;
  localparam logic [CMD_W-1:0] CHAR_UA = 8'h41;
  localparam logic [CMD_W-1:0] CHAR_UZ = 8'h5A;

  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT  = 8'd180;
  localparam logic [STEP_W-1:0]  STEP_RESET   = 5'd5;
  localparam logic [SPEED_W-1:0] SPEED_RESET  = 4'd1;
  localparam logic [DIST_W-1:0]  DIST_MAX     = 12'd999;
  localparam logic [DELAY_W-1:0] DELAY_BASE   = 17'd110000;
  localparam logic [DELAY_W-1:0] DELAY_STEP   = 17'd5000;
  localparam logic [DELAY_W-1:0] DELAY_MIN    = 17'd65000;

  typedef enum logic [2:0] {
    DIR_STOP = 3'b001,
    DIR_UP   = 3'b010,
    DIR_DOWN = 3'b100
  } dir_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] angle;
    logic [SPEED_W-1:0] speed;
  } sweep_view_t;

  typedef struct packed {
    logic [31:0] low;
    logic [15:0] high;
    logic        update;
  } disp_t;

  function automatic logic [7:0] seg_of(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'h3F;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5B;
      4'd3:    code = 8'h4F;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6D;
      4'd6:    code = 8'h7D;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7F;
      4'd9:    code = 8'h6F;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  // exact for x below 1029
  function automatic logic [6:0] div10(input logic [9:0] x);
    logic [17:0] prod;
    prod = 18'(x) * 18'd205;
    return prod[17:11];
  endfunction

  function automatic logic [3:0] mod10(input logic [9:0] x, input logic [6:0] q);
    logic [9:0] qt;
    qt = 10'(q) * 10'd10;
    return 4'(x - qt);
  endfunction

endpackage

// ===== sv/rsc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep step input channel
// Valid/ready channel carrying the command byte and distance sample.
// ----------------------------------------------------------------------------
interface rsc_in_if;
  import rsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command_char;
  logic [DIST_W-1:0]  distance_cm;

  modport source (output valid, command_char, distance_cm, input ready);
  modport sink   (input valid, command_char, distance_cm, output ready);
endinterface

// ===== sv/rsc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep result output channel
// Valid/ready channel carrying servo pulse, display words and step delay.
// ----------------------------------------------------------------------------
interface rsc_out_if;
  import rsc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SERVO_W-1:0] servo_pulse;
  logic [31:0]        display_low;
  logic [15:0]        display_high;
  logic               display_update;
  logic [DELAY_W-1:0] sweep_delay_us;

  modport source (output valid, servo_pulse, display_low, display_high, display_update,
                  sweep_delay_us, input ready);
  modport sink   (input valid, servo_pulse, display_low, display_high, display_update,
                  sweep_delay_us, output ready);
endinterface

// ===== sv/rsc_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the step size register write data.
// ----------------------------------------------------------------------------
interface rsc_cfg_if;
  import rsc_pkg::*;

  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== sv/rsc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sweep core
// Command decode, bound and speed registers, step size register and the
// bouncing angle update.
// ----------------------------------------------------------------------------
module rsc_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [rsc_pkg::CMD_W-1:0]  cmd,
  input  logic                       cfg_we,
  input  logic [rsc_pkg::STEP_W-1:0] cfg_data,
  output rsc_pkg::sweep_view_t       view
);
  import rsc_pkg::*;

  logic [ANGLE_W-1:0] angle, angle_next;
  dir_t               dir, dir_next;
  logic [ANGLE_W-1:0] lower, lower_next;
  logic [ANGLE_W-1:0] upper, upper_next;
  logic [SPEED_W-1:0] speed, speed_next;
  logic [STEP_W-1:0]  step_size;
  logic [ANGLE_W-1:0] letter_val;
  logic [ANGLE_W:0]   sum;
  logic [ANGLE_W-1:0] step_ext;

  always_comb begin
    speed_next = speed;
    lower_next = lower;
    upper_next = upper;
    letter_val = '0;
    if (cmd >= CHAR_0 && cmd <= CHAR_9) begin
      speed_next = SPEED_W'(cmd - CHAR_0);
    end else if (cmd >= CHAR_LA && cmd <= CHAR_LZ) begin
      letter_val = ANGLE_W'((cmd - CHAR_LA) * 8'd10);
      lower_next = letter_val;
    end else if (cmd >= CHAR_UA && cmd <= CHAR_UZ) begin
      letter_val = ANGLE_W'((cmd - CHAR_UA) * 8'd10);
      upper_next = (letter_val > ANGLE_LIMIT) ? ANGLE_LIMIT : letter_val;
    end
  end

  always_comb begin
    dir_next = dir;
    if (angle >= upper_next) begin
      dir_next = DIR_DOWN;
    end else if (angle <= lower_next) begin
      dir_next = DIR_UP;
    end
    step_ext = ANGLE_W'(step_size);
    sum = {1'b0, angle} + {1'b0, step_ext};
    case (dir_next)
      DIR_UP:   angle_next = sum[ANGLE_W] ? {ANGLE_W{1'b1}} : sum[ANGLE_W-1:0];
      DIR_DOWN: angle_next = (angle >= step_ext) ? (angle - step_ext) : '0;
      default:  angle_next = angle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      angle     <= '0;
      dir       <= DIR_STOP;
      lower     <= '0;
      upper     <= ANGLE_LIMIT;
      speed     <= SPEED_RESET;
      step_size <= STEP_RESET;
    end else begin
      if (cfg_we) begin
        step_size <= cfg_data;
      end
      if (advance) begin
        angle <= angle_next;
        dir   <= dir_next;
        lower <= lower_next;
        upper <= upper_next;
        speed <= speed_next;
      end
    end
  end

  assign view.angle = angle;
  assign view.speed = speed_next;
endmodule

// ===== sv/rsc_display.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seven-segment formatter
// Splits distance and angle into decimal digits and packs segment bytes.
// ----------------------------------------------------------------------------
module rsc_display (
  input  logic [rsc_pkg::DIST_W-1:0]  distance,
  input  logic [rsc_pkg::ANGLE_W-1:0] angle,
  output rsc_pkg::disp_t              disp
);
  import rsc_pkg::*;

  logic [9:0] d;
  logic [9:0] a;
  logic [6:0] d_q1, a_q1;
  logic [6:0] d_q2, a_q2;
  logic [3:0] d_units, d_tens, a_units, a_tens;

  always_comb begin
    d       = distance[9:0];
    a       = 10'(angle);
    d_q1    = div10(d);
    d_units = mod10(d, d_q1);
    d_q2    = div10(10'(d_q1));
    d_tens  = mod10(10'(d_q1), d_q2);
    a_q1    = div10(a);
    a_units = mod10(a, a_q1);
    a_q2    = div10(10'(a_q1));
    a_tens  = mod10(10'(a_q1), a_q2);
    if (distance <= DIST_MAX) begin
      disp.low    = {seg_of(a_units), seg_of(d_q2[3:0]), seg_of(d_tens), seg_of(d_units)};
      disp.high   = {seg_of(a_q2[3:0]), seg_of(a_tens)};
      disp.update = 1'b1;
    end else begin
      disp.low    = '0;
      disp.high   = '0;
      disp.update = 1'b0;
    end
  end
endmodule

// ===== sv/radar_sweep_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radar sweep controller
// One sweep step per input word: decode the command byte, report servo
// pulse, segment words and step delay, then bounce the angle.
// ----------------------------------------------------------------------------
// Takes one word per clock unless a held result stalls the output; returns one
// result word per input word: the input register holds the step, then decode,
// digit split and angle update run in one pass into the result register,
// which lets the next word enter while a result waits to be taken. The user
// must write step size via cfg while the block is idle; the block does not check.
module radar_sweep_controller (
  input  logic       clk,
  input  logic       rst,
  rsc_in_if.sink     sweep_in,
  rsc_out_if.source  sweep_out,
  rsc_cfg_if.sink    cfg
);
  import rsc_pkg::*;

  logic               stage_valid;
  logic [CMD_W-1:0]   stage_cmd;
  logic [DIST_W-1:0]  stage_dist;
  logic               advance;
  sweep_view_t        view;
  disp_t              disp;
  logic [SERVO_W-1:0] servo;
  logic [DELAY_W-1:0] delay;

  assign advance        = stage_valid && (!sweep_out.valid || sweep_out.ready);
  assign sweep_in.ready = !stage_valid || advance;
  assign cfg.ready      = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (sweep_in.ready) begin
      stage_valid <= sweep_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_in.valid && sweep_in.ready) begin
      stage_cmd  <= sweep_in.command_char;
      stage_dist <= sweep_in.distance_cm;
    end
  end

  rsc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .cmd      (stage_cmd),
    .cfg_we   (cfg.valid && cfg.ready),
    .cfg_data (cfg.data),
    .view     (view)
  );

  rsc_display u_display (
    .distance (stage_dist),
    .angle    (view.angle),
    .disp     (disp)
  );

  assign servo = SERVO_W'(view.angle) * 12'd10;
  assign delay = DELAY_BASE - DELAY_STEP * DELAY_W'(view.speed);

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_out.valid <= 1'b0;
    end else if (advance) begin
      sweep_out.valid <= 1'b1;
    end else if (sweep_out.ready) begin
      sweep_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sweep_out.servo_pulse    <= servo;
      sweep_out.display_low    <= disp.low;
      sweep_out.display_high   <= disp.high;
      sweep_out.display_update <= disp.update;
      sweep_out.sweep_delay_us <= delay;
    end
  end

  a_blank_display: assert property (@(posedge clk) disable iff (rst)
    sweep_out.valid && !sweep_out.display_update |->
      sweep_out.display_low == '0 && sweep_out.display_high == '0)
    else $error("blank display word carries segment data");

  a_delay_range: assert property (@(posedge clk) disable iff (rst)
    sweep_out.valid |->
      sweep_out.sweep_delay_us >= DELAY_MIN && sweep_out.sweep_delay_us <= DELAY_BASE)
    else $error("step delay out of range");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    stage_valid && !advance |=> stage_valid)
    else $error("stalled step word dropped");

  a_result_drain: assert property (@(posedge clk) disable iff (rst)
    sweep_out.valid && sweep_out.ready && !advance |=> !sweep_out.valid)
    else $error("taken result word repeated");
endmodule
